// ----- rtl/core/fqmm_pkg.sv -----
// Shared types and constants for the min/max FIFO queue unit.
// Operation codes, status codes, field widths and the controller/datapath
// interface structs. No dependencies.
package fqmm_pkg;

	// Fixed field widths
	localparam int DATA_W  = 32;
	localparam int FUNC_W  = 2;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 5;

	// Default ring depth
	localparam int DEPTH_DEF = 16;

	// Operation codes
	localparam logic [FUNC_W-1:0] FUNC_ENQ    = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_DEQ    = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_PEEK   = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_MINMAX = 2'd3;

	// Result status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	// Commands from controller to datapath
	typedef struct packed {
		logic enq;        // write data_in at tail
		logic deq;        // read head, pop
		logic peek;       // read head and tail - 1
		logic scan_start; // first read of a min/max scan
		logic scan_run;   // scan in progress: fold read data
		logic err_full;   // enqueue refused
		logic err_empty;  // non-enqueue operation on empty queue
	} fqmm_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic empty;
		logic full;
		logic scan_zero;  // no scan reads left to issue
	} fqmm_stat_t;

endpackage

// ----- rtl/core/fifo_queue_min_max_unit.sv -----
// Top level of the min/max FIFO queue unit: controller plus datapath.
// Depends on fqmm_pkg, fqmm_ctrl and fqmm_dpath.
//
// Usage:
//   Command channel: an operation (func, data_in) transfers on a rising edge
//   with start high and busy low. func selects enqueue, dequeue, peek front
//   and rear, or min/max over all held entries.
//   Result channel: done is high for exactly one cycle per operation, with
//   status, the value fields and count valid in that cycle.
//   Enqueue, dequeue, peek and any refused operation: result in the next cycle
//   after the transfer, busy stays low, so one operation per cycle is sustained.
//   Min/max on N held entries: busy is high while the scan reads one entry per
//   cycle from the ring memory; done follows the last read, and a new operation
//   may transfer in that done cycle.
//   Reset empties the queue (pointers and count cleared); stored entries are
//   not cleared and need no clearing pass. The receiver cannot stall: every
//   result is taken in its done cycle.
module fifo_queue_min_max_unit
	import fqmm_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [FUNC_W-1:0]         func,
	input  logic signed [DATA_W-1:0]  data_in,
	output logic                      busy,
	output logic                      done,
	output logic [STAT_W-1:0]         status,
	output logic signed [DATA_W-1:0]  front_value,
	output logic signed [DATA_W-1:0]  rear_value,
	output logic signed [DATA_W-1:0]  min_value,
	output logic signed [DATA_W-1:0]  max_value,
	output logic [COUNT_W-1:0]        count
);

	fqmm_cmd_t  cmd;
	fqmm_stat_t stat;

	fqmm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (func),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	fqmm_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.data_in     (data_in),
		.stat        (stat),
		.status      (status),
		.front_value (front_value),
		.rear_value  (rear_value),
		.min_value   (min_value),
		.max_value   (max_value),
		.count       (count)
	);

endmodule

// ----- rtl/core/fqmm_ctrl.sv -----
// Controller for the min/max FIFO queue unit: decodes operations, runs the
// scan state machine and raises the result strobe. Depends on fqmm_pkg.
module fqmm_ctrl
	import fqmm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [FUNC_W-1:0] func,
	input  fqmm_stat_t        stat,
	output fqmm_cmd_t         cmd,
	output logic              busy,
	output logic              done
);

	typedef enum logic {
		S_IDLE,
		S_SCAN
	} state_t;

	state_t state_q;
	logic   done_q;
	logic   accept;
	logic   scan_last;

	// Operation decode on transfer
	always_comb begin
		accept         = start && (state_q == S_IDLE);
		cmd.enq        = accept && (func == FUNC_ENQ) && !stat.full;
		cmd.err_full   = accept && (func == FUNC_ENQ) && stat.full;
		cmd.err_empty  = accept && (func != FUNC_ENQ) && stat.empty;
		cmd.deq        = accept && (func == FUNC_DEQ) && !stat.empty;
		cmd.peek       = accept && (func == FUNC_PEEK) && !stat.empty;
		cmd.scan_start = accept && (func == FUNC_MINMAX) && !stat.empty;
		cmd.scan_run   = (state_q == S_SCAN);
		scan_last      = cmd.scan_run && stat.scan_zero;
	end

	// State and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (accept && !cmd.scan_start) || scan_last;
			case (state_q)
				S_IDLE: begin
					if (cmd.scan_start) state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (stat.scan_zero) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q == S_SCAN);
	assign done = done_q;

endmodule

// ----- rtl/core/fqmm_dpath.sv -----
// Datapath for the min/max FIFO queue unit: entry ring memory, pointers,
// count, scan min/max fold and result registers. Depends on fqmm_pkg.
module fqmm_dpath
	import fqmm_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  fqmm_cmd_t                 cmd,
	input  logic signed [DATA_W-1:0]  data_in,
	output fqmm_stat_t                stat,
	output logic [STAT_W-1:0]         status,
	output logic signed [DATA_W-1:0]  front_value,
	output logic signed [DATA_W-1:0]  rear_value,
	output logic signed [DATA_W-1:0]  min_value,
	output logic signed [DATA_W-1:0]  max_value,
	output logic [COUNT_W-1:0]        count
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	typedef enum logic [1:0] {
		K_NONE,
		K_FRONT,
		K_PEEK,
		K_MINMAX
	} kind_t;

	logic signed [DATA_W-1:0] mem [DEPTH];

	logic [PTR_W-1:0]         head_q, tail_q, scan_ptr_q;
	logic [CNT_W-1:0]         cnt_q, cnt_d, left_q;
	logic [PTR_W-1:0]         rd_a_addr, tail_prev, head_next, tail_next, scan_next;
	logic signed [DATA_W-1:0] rd_a_q, rd_b_q;
	logic signed [DATA_W-1:0] min_q, max_q;
	logic                     first_q;
	logic [STAT_W-1:0]        res_status_q;
	logic [CNT_W-1:0]         res_count_q;
	kind_t                    res_kind_q;
	logic                     any_op;

	// Ring pointer arithmetic
	always_comb begin
		head_next = (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
		tail_next = (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;
		scan_next = (scan_ptr_q == PTR_LAST) ? '0 : scan_ptr_q + 1'b1;
		tail_prev = (tail_q == '0) ? PTR_LAST : tail_q - 1'b1;
		rd_a_addr = cmd.scan_run ? scan_ptr_q : head_q;
	end

	// Count after the operation
	always_comb begin
		cnt_d = cnt_q;
		if (cmd.enq) cnt_d = cnt_q + 1'b1;
		else if (cmd.deq) cnt_d = cnt_q - 1'b1;
	end

	assign any_op = cmd.enq | cmd.deq | cmd.peek | cmd.scan_start |
			cmd.err_full | cmd.err_empty;

	always_comb begin
		stat.empty     = (cnt_q == '0);
		stat.full      = (cnt_q == CNT_FULL);
		stat.scan_zero = (left_q == '0);
	end

	// Entry memory: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (cmd.enq) mem[tail_q] <= data_in;
		rd_a_q <= mem[rd_a_addr];
		rd_b_q <= mem[tail_prev];
	end

	// Pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (cmd.enq) tail_q <= tail_next;
			if (cmd.deq) head_q <= head_next;
			cnt_q <= cnt_d;
		end
	end

	// Scan address walk and read counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_ptr_q <= '0;
			left_q     <= '0;
			first_q    <= 1'b0;
		end else if (cmd.scan_start) begin
			scan_ptr_q <= head_next;
			left_q     <= cnt_q - 1'b1;
			first_q    <= 1'b1;
		end else if (cmd.scan_run) begin
			first_q <= 1'b0;
			if (left_q != '0) begin
				scan_ptr_q <= scan_next;
				left_q     <= left_q - 1'b1;
			end
		end
	end

	// Min/max fold, one entry per cycle
	always_ff @(posedge clk) begin
		if (cmd.scan_run) begin
			if (first_q || (rd_a_q < min_q)) min_q <= rd_a_q;
			if (first_q || (rd_a_q > max_q)) max_q <= rd_a_q;
		end
	end

	// Result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_status_q <= ST_OK;
			res_count_q  <= '0;
			res_kind_q   <= K_NONE;
		end else if (any_op) begin
			res_count_q <= cnt_d;
			if (cmd.err_full) begin
				res_status_q <= ST_FULL;
				res_kind_q   <= K_NONE;
			end else if (cmd.err_empty) begin
				res_status_q <= ST_EMPTY;
				res_kind_q   <= K_NONE;
			end else begin
				res_status_q <= ST_OK;
				if (cmd.deq) res_kind_q <= K_FRONT;
				else if (cmd.peek) res_kind_q <= K_PEEK;
				else if (cmd.scan_start) res_kind_q <= K_MINMAX;
				else res_kind_q <= K_NONE;
			end
		end
	end

	// Result fields, zero where the operation gives no value
	always_comb begin
		status      = res_status_q;
		count       = COUNT_W'(res_count_q);
		front_value = ((res_kind_q == K_FRONT) || (res_kind_q == K_PEEK)) ? rd_a_q : '0;
		rear_value  = (res_kind_q == K_PEEK) ? rd_b_q : '0;
		min_value   = (res_kind_q == K_MINMAX) ? min_q : '0;
		max_value   = (res_kind_q == K_MINMAX) ? max_q : '0;
	end

endmodule

// ----- bench/tb_fifo_queue_min_max_unit.sv -----
// Self-checking bench for fifo_queue_min_max_unit: a queue-behavior predictor,
// a command driver and a result monitor. Depends on fqmm_pkg and the unit.
`timescale 1ns / 100ps

module tb_fifo_queue_min_max_unit
	import fqmm_pkg::*;
;

	localparam int DEPTH      = DEPTH_DEF;
	localparam int RANDOM_OPS = 550;
	localparam int STALL_MAX  = 4000;

	// One queued command and the sender gap rate that goes with it
	typedef struct {
		logic [FUNC_W-1:0]        op;
		logic signed [DATA_W-1:0] val;
		int                       idle_pct;
	} queue_cmd_t;

	// Outcome of one queue operation
	typedef struct {
		logic [STAT_W-1:0]        stat;
		logic signed [DATA_W-1:0] front;
		logic signed [DATA_W-1:0] rear;
		logic signed [DATA_W-1:0] lo;
		logic signed [DATA_W-1:0] hi;
		logic [COUNT_W-1:0]       cnt;
	} queue_outcome_t;

	logic                     clk     = 1'b0;
	logic                     arst_n  = 1'b0;
	logic                     start   = 1'b0;
	logic [FUNC_W-1:0]        func    = FUNC_ENQ;
	logic signed [DATA_W-1:0] data_in = '0;
	logic                     busy;
	logic                     done;
	logic [STAT_W-1:0]        status;
	logic signed [DATA_W-1:0] front_value;
	logic signed [DATA_W-1:0] rear_value;
	logic signed [DATA_W-1:0] min_value;
	logic signed [DATA_W-1:0] max_value;
	logic [COUNT_W-1:0]       count;

	queue_cmd_t     op_backlog[$];
	queue_outcome_t op_outcomes[$];
	logic           cmd_taken   = 1'b0;
	int             xfer_total  = 0;
	int             fail_cnt    = 0;
	int             stall_count = 0;
	int             ops_added   = 0;

	// Shadow ring state
	logic signed [DATA_W-1:0] shadow_ring[DEPTH];
	int                       shadow_head = 0;
	int                       shadow_tail = 0;
	int                       shadow_cnt  = 0;

	fifo_queue_min_max_unit #(.DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.func(func),
		.data_in(data_in),
		.busy(busy),
		.done(done),
		.status(status),
		.front_value(front_value),
		.rear_value(rear_value),
		.min_value(min_value),
		.max_value(max_value),
		.count(count)
	);

	always #5 clk = ~clk;

	// Apply one operation to the shadow ring and return its outcome
	function automatic queue_outcome_t queue_op_outcome(input logic [FUNC_W-1:0] op,
			input logic signed [DATA_W-1:0] val);
		queue_outcome_t r;
		int p;
		r.stat  = ST_OK;
		r.front = '0;
		r.rear  = '0;
		r.lo    = '0;
		r.hi    = '0;
		if (op == FUNC_ENQ) begin
			if (shadow_cnt >= DEPTH) begin
				r.stat = ST_FULL;
			end else begin
				shadow_ring[shadow_tail] = val;
				shadow_tail = (shadow_tail + 1) % DEPTH;
				shadow_cnt++;
			end
		end else if (shadow_cnt == 0) begin
			r.stat = ST_EMPTY;
		end else if (op == FUNC_DEQ) begin
			r.front = shadow_ring[shadow_head];
			shadow_head = (shadow_head + 1) % DEPTH;
			shadow_cnt--;
		end else if (op == FUNC_PEEK) begin
			r.front = shadow_ring[shadow_head];
			r.rear  = shadow_ring[(shadow_tail + DEPTH - 1) % DEPTH];
		end else begin
			// scan front to rear
			p = shadow_head;
			r.lo = shadow_ring[p];
			r.hi = shadow_ring[p];
			for (int i = 0; i < shadow_cnt; i++) begin
				if (shadow_ring[p] < r.lo) r.lo = shadow_ring[p];
				if (shadow_ring[p] > r.hi) r.hi = shadow_ring[p];
				p = (p + 1) % DEPTH;
			end
		end
		r.cnt = shadow_cnt[COUNT_W-1:0];
		return r;
	endfunction

	task automatic check_field(input string name, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %h, actual %h", name, want, got);
			fail_cnt++;
		end
	endtask

	// Queue one command; sender gap rate follows the run phase
	task automatic add_op(input logic [FUNC_W-1:0] op, input logic signed [DATA_W-1:0] val);
		queue_cmd_t c;
		c.op  = op;
		c.val = val;
		if (ops_added < 192)
			c.idle_pct = 12;
		else if (ops_added < 384)
			c.idle_pct = 76;
		else
			c.idle_pct = 0;
		op_backlog.push_back(c);
		ops_added++;
	endtask

	// Mix of extremes, small values near zero and full-width random values
	function automatic logic signed [DATA_W-1:0] pick_value();
		int sel;
		sel = $urandom_range(9);
		case (sel)
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2, 3: return $signed($urandom_range(16)) - 8;
			default: return $urandom;
		endcase
	endfunction

	// Driver: present the next command after the last one transferred
	always @(negedge clk) begin
		if (arst_n && (!start || cmd_taken)) begin
			if (op_backlog.size() != 0 && $urandom_range(99) >= op_backlog[0].idle_pct) begin
				start   <= 1'b1;
				func    <= op_backlog[0].op;
				data_in <= op_backlog[0].val;
				void'(op_backlog.pop_front());
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: check results, then log command transfers into the predictor
	always @(posedge clk) begin
		queue_outcome_t want;
		if (arst_n) begin
			if (done) begin
				if (op_outcomes.size() == 0) begin
					$error("result with no operation outstanding");
					fail_cnt++;
				end else begin
					want = op_outcomes.pop_front();
					check_field("status", DATA_W'(want.stat), DATA_W'(status));
					check_field("front_value", want.front, front_value);
					check_field("rear_value", want.rear, rear_value);
					check_field("min_value", want.lo, min_value);
					check_field("max_value", want.hi, max_value);
					check_field("count", DATA_W'(want.cnt), DATA_W'(count));
				end
			end
			cmd_taken <= start && !busy;
			if (start && !busy) begin
				op_outcomes.push_back(queue_op_outcome(func, data_in));
				xfer_total++;
			end
			// watchdog on cycles with no transfer either way
			if ((start && !busy) || done)
				stall_count = 0;
			else
				stall_count++;
			if (stall_count >= STALL_MAX) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// Stimulus and end of run
	initial begin
		int burst;
		int mode;
		int roll;
		int t_enq;
		int t_deq;
		int n;
		logic [FUNC_W-1:0] op;

		// directed: empty-queue errors, single entry, fill to full, wrap
		add_op(FUNC_PEEK, 32'sh7FFF_FFFF);
		add_op(FUNC_DEQ, 32'sh8000_0000);
		add_op(FUNC_MINMAX, '0);
		add_op(FUNC_ENQ, 32'sh7FFF_FFFF);
		add_op(FUNC_PEEK, '0);
		add_op(FUNC_MINMAX, '0);
		add_op(FUNC_ENQ, 32'sh8000_0000);
		add_op(FUNC_ENQ, '0);
		add_op(FUNC_ENQ, -1);
		add_op(FUNC_ENQ, 1);
		add_op(FUNC_ENQ, 32'sh7FFF_FFFF);
		add_op(FUNC_ENQ, 32'sh5555_5555);
		add_op(FUNC_ENQ, 32'shAAAA_AAAA);
		for (int i = 0; i < 8; i++)
			add_op(FUNC_ENQ, $urandom);
		add_op(FUNC_ENQ, 32'sh1234_5678);
		add_op(FUNC_MINMAX, '0);
		add_op(FUNC_DEQ, '0);
		add_op(FUNC_PEEK, '0);

		// random: bursts that lean toward filling, draining or neither
		n = 0;
		while (n < RANDOM_OPS) begin
			burst = $urandom_range(40, 10);
			mode  = $urandom_range(2);
			case (mode)
				0: begin
					t_enq = 65;
					t_deq = 78;
				end
				1: begin
					t_enq = 20;
					t_deq = 75;
				end
				default: begin
					t_enq = 40;
					t_deq = 70;
				end
			endcase
			for (int j = 0; j < burst && n < RANDOM_OPS; j++) begin
				roll = $urandom_range(99);
				if (roll < t_enq)
					op = FUNC_ENQ;
				else if (roll < t_deq)
					op = FUNC_DEQ;
				else if ($urandom_range(1) == 0)
					op = FUNC_PEEK;
				else
					op = FUNC_MINMAX;
				add_op(op, pick_value());
				n++;
			end
		end

		// reset once, release away from the active edge
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// wait for every command to transfer and every result to arrive
		do
			@(negedge clk);
		while (xfer_total < ops_added || op_outcomes.size() != 0);
		repeat (DEPTH + 4) @(negedge clk);

		if (fail_cnt == 0 && op_outcomes.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
